FILE: hdl/cpr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants
// Sizes, controller state and command/status structs of the clock
// page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

	localparam int NumFrames    = 16;
	localparam int VirtPages    = 32;
	localparam int PageSize     = 1024;
	localparam int ProcSlots    = 8;
	localparam int FrameW       = $clog2(NumFrames);
	localparam int PageW        = $clog2(VirtPages);
	localparam int SlotW        = $clog2(ProcSlots);
	localparam int AddrW        = 15;
	localparam int OffW         = $clog2(PageSize);
	localparam int PtW          = SlotW + PageW;
	localparam int CountW       = $clog2(NumFrames + 1);

	localparam logic MODE_ACCESS  = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_INSTALL,
		ST_RELEASE
	} cpr_state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;       // capture input transaction
		logic lookup;      // page table read result registered
		logic do_hit;      // set ref bit, report hit
		logic sweep_step;  // one clock hand step
		logic install;     // install new page (with optional eviction)
		logic release_pt;  // clear one page-table entry of the slot
		logic release_fr;  // free frames of the slot
		logic done;        // present result
	} cpr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_release;
		logic present;
		logic free_found;
		logic victim_found;
		logic pt_last;
	} cpr_stat_t;

endpackage
`default_nettype wire

FILE: hdl/cpr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_ctrl: controller
// Sequences lookup, clock sweep, install and release of one transaction.
// ----------------------------------------------------------------------------
module cpr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  cpr_pkg::cpr_stat_t      stat,
	output cpr_pkg::cpr_cmd_t       cmd
);
	import cpr_pkg::*;

	cpr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				if (stat.is_release)        state_d = ST_RELEASE;
				else if (stat.present)      state_d = ST_IDLE;
				else if (stat.free_found)   state_d = ST_IDLE;
				else                        state_d = ST_SWEEP;
			end
			ST_SWEEP:   if (stat.victim_found) state_d = ST_INSTALL;
			ST_INSTALL: state_d = ST_IDLE;
			ST_RELEASE: if (stat.pt_last) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:   cmd.latch = start;
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (stat.is_release) begin
					cmd.release_fr = 1'b1;
				end else if (stat.present) begin
					cmd.do_hit = 1'b1;
					cmd.done   = 1'b1;
				end else if (stat.free_found) begin
					cmd.install = 1'b1;
					cmd.done    = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (!stat.victim_found) cmd.sweep_step = 1'b1;
			end
			ST_INSTALL: begin
				cmd.install = 1'b1;
				cmd.done    = 1'b1;
			end
			ST_RELEASE: begin
				cmd.release_pt = 1'b1;
				cmd.done       = stat.pt_last;
			end
			default: ;
		endcase
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> !cmd.done) else $error("back to back results");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> state_q == ST_IDLE) else $error("not idle after result");
	a_no_latch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |-> !busy) else $error("latch while busy");

endmodule
`default_nettype wire

FILE: hdl/cpr_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_dpath: datapath
// Frame table in flops, page table memory with a per-entry present bit
// array, clock hand, and result registers.
// ----------------------------------------------------------------------------
module cpr_dpath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          mode,
	input  wire logic [cpr_pkg::SlotW-1:0]     process_slot,
	input  wire logic [cpr_pkg::AddrW-1:0]     address,
	input  cpr_pkg::cpr_cmd_t                  cmd,
	output cpr_pkg::cpr_stat_t                 stat,
	output logic                               done,
	output logic                               hit,
	output logic [cpr_pkg::FrameW-1:0]         frame_number,
	output logic                               evicted,
	output logic [cpr_pkg::SlotW-1:0]          evicted_process,
	output logic [cpr_pkg::PageW-1:0]          evicted_page,
	output logic [cpr_pkg::CountW-1:0]         freed_count
);
	import cpr_pkg::*;

	localparam int PtDepth = ProcSlots * VirtPages;

	// transaction registers
	logic              mode_q;
	logic [SlotW-1:0]  slot_q;
	logic [PageW-1:0]  page_q;
	logic [PageW-1:0]  rel_idx_q;

	// frame table
	logic [NumFrames-1:0] fvalid_q, fref_q;
	logic [SlotW-1:0]     fowner_q [NumFrames];
	logic [PageW-1:0]     fvpage_q [NumFrames];
	logic [FrameW-1:0]    hand_q;

	// page table: present bits in flops, frame numbers in memory
	logic [PtDepth-1:0]   pt_present_q;
	logic [FrameW-1:0]    pt_mem [PtDepth];
	logic [FrameW-1:0]    pt_rd_q;
	logic                 pt_pres_rd_q;

	logic                free_any;
	logic [FrameW-1:0]   free_idx;
	logic [FrameW-1:0]   free_or_victim;

	logic [PtW-1:0] idx;
	assign idx = {slot_q, page_q};

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			slot_q <= process_slot;
			page_q <= address[OffW +: PageW];
		end
	end

	// registered read, address from input at latch
	always_ff @(posedge clk) begin
		pt_rd_q      <= pt_mem[{process_slot, address[OffW +: PageW]}];
		pt_pres_rd_q <= pt_present_q[{process_slot, address[OffW +: PageW]}];
		if (cmd.install) pt_mem[idx] <= free_or_victim;
	end

	// lowest free frame
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = NumFrames - 1; i >= 0; i--) begin
			if (!fvalid_q[i]) begin
				free_any = 1'b1;
				free_idx = FrameW'(i);
			end
		end
	end

	logic victim_ok;
	assign victim_ok = fvalid_q[hand_q] && !fref_q[hand_q];

	assign free_or_victim = free_any ? free_idx : hand_q;

	logic [NumFrames-1:0] rel_match;
	always_comb begin
		for (int i = 0; i < NumFrames; i++)
			rel_match[i] = fvalid_q[i] && (fowner_q[i] == slot_q);
	end

	logic [CountW-1:0] rel_count;
	always_comb begin
		rel_count = '0;
		for (int i = 0; i < NumFrames; i++)
			rel_count = rel_count + CountW'(rel_match[i]);
	end

	assign stat.is_release   = (mode_q == MODE_RELEASE);
	assign stat.present      = pt_pres_rd_q;
	assign stat.free_found   = free_any;
	assign stat.victim_found = victim_ok;
	assign stat.pt_last      = (rel_idx_q == PageW'(VirtPages - 1));

	logic [PtW-1:0] vidx;
	assign vidx = {fowner_q[hand_q], fvpage_q[hand_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q     <= '0;
			fref_q       <= '0;
			hand_q       <= '0;
			pt_present_q <= '0;
			rel_idx_q    <= '0;
			done         <= 1'b0;
			for (int i = 0; i < NumFrames; i++) begin
				fowner_q[i] <= '0;
				fvpage_q[i] <= '0;
			end
		end else begin
			done <= cmd.done;
			if (cmd.latch) rel_idx_q <= '0;
			if (cmd.do_hit) fref_q[pt_rd_q] <= 1'b1;
			if (cmd.sweep_step) begin
				if (fvalid_q[hand_q]) fref_q[hand_q] <= 1'b0;
				hand_q <= (hand_q == FrameW'(NumFrames - 1)) ? '0 : hand_q + 1'b1;
			end
			if (cmd.install) begin
				if (!free_any) pt_present_q[vidx] <= 1'b0;
				pt_present_q[idx]          <= 1'b1;
				fvalid_q[free_or_victim]   <= 1'b1;
				fref_q[free_or_victim]     <= 1'b1;
				fowner_q[free_or_victim]   <= slot_q;
				fvpage_q[free_or_victim]   <= page_q;
			end
			if (cmd.release_fr) begin
				for (int i = 0; i < NumFrames; i++) begin
					if (rel_match[i]) begin
						fvalid_q[i] <= 1'b0;
						fref_q[i]   <= 1'b0;
						fowner_q[i] <= '0;
						fvpage_q[i] <= '0;
					end
				end
			end
			if (cmd.release_pt) begin
				pt_present_q[{slot_q, rel_idx_q}] <= 1'b0;
				rel_idx_q <= rel_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.release_fr) begin
			hit             <= 1'b0;
			frame_number    <= '0;
			evicted         <= 1'b0;
			evicted_process <= '0;
			evicted_page    <= '0;
			freed_count     <= rel_count;
		end else if (cmd.do_hit) begin
			hit             <= 1'b1;
			frame_number    <= pt_rd_q;
			evicted         <= 1'b0;
			evicted_process <= '0;
			evicted_page    <= '0;
			freed_count     <= '0;
		end else if (cmd.install) begin
			hit             <= 1'b0;
			frame_number    <= free_or_victim;
			evicted         <= !free_any;
			evicted_process <= free_any ? '0 : fowner_q[hand_q];
			evicted_page    <= free_any ? '0 : fvpage_q[hand_q];
			freed_count     <= '0;
		end
	end

	a_install_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.install && !free_any |-> victim_ok) else $error("bad victim");
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_hit |-> fvalid_q[pt_rd_q]) else $error("hit on invalid frame");
	a_sweep_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |-> !free_any) else $error("sweep with free frame");

endmodule
`default_nettype wire

FILE: hdl/clock_page_replacement.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clock_page_replacement: clock (second-chance) page replacement
// Per-process page tables over 16 shared frames.
// ----------------------------------------------------------------------------
// Usage: drive mode, process_slot and address with start high while busy
// is low; that edge accepts the transaction. mode 0 is a memory access,
// mode 1 releases every frame and page-table entry of the process.
// One result follows each transaction, shown for one cycle with done high;
// the receiver cannot stall it, so it must take it then.
// Accept to done: a hit or a free-frame miss ends at the page-table
// lookup; a miss with all frames in use then takes clock-hand steps
// (at most 16 steps, one per frame whose reference bit gets cleared)
// and installs; a release frees its frames at lookup, then clears the
// 32 page-table entries, one per cycle. busy is high from the cycle
// after accept, when the page-table read is ready, until done.
// Reset clears all frames, page tables and the hand at once.
// ----------------------------------------------------------------------------
module clock_page_replacement (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          mode,
	input  wire logic [cpr_pkg::SlotW-1:0]     process_slot,
	input  wire logic [cpr_pkg::AddrW-1:0]     address,
	output logic                               done,
	output logic                               hit,
	output logic [cpr_pkg::FrameW-1:0]         frame_number,
	output logic                               evicted,
	output logic [cpr_pkg::SlotW-1:0]          evicted_process,
	output logic [cpr_pkg::PageW-1:0]          evicted_page,
	output logic [cpr_pkg::CountW-1:0]         freed_count
);
	import cpr_pkg::*;

	cpr_cmd_t  cmd;
	cpr_stat_t stat;

	cpr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	cpr_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.mode            (mode),
		.process_slot    (process_slot),
		.address         (address),
		.cmd             (cmd),
		.stat            (stat),
		.done            (done),
		.hit             (hit),
		.frame_number    (frame_number),
		.evicted         (evicted),
		.evicted_process (evicted_process),
		.evicted_page    (evicted_page),
		.freed_count     (freed_count)
	);

endmodule
`default_nettype wire
